/* hw/rtl/mma_pkg.sv */
// Shared types and constants of the matrix multiply-accumulate block.
package mma_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int QDEPTH  = 2;

  // Request op codes as seen on the input channel
  localparam logic [OP_W-1:0] OP_WR_A = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_B = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_C = 3'd2;
  localparam logic [OP_W-1:0] OP_MAC  = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_C = 3'd4;

  // Classified command handed from the front to the back
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WR_A,
    CMD_WR_B,
    CMD_WR_C,
    CMD_MAC,
    CMD_RD_C
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } req_t;

endpackage

/* hw/rtl/mma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mma_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module mma_front #(
  parameter int DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mma_pkg::OP_W-1:0]           in_op,
  input  logic [mma_pkg::IDX_W-1:0]          in_row,
  input  logic [mma_pkg::IDX_W-1:0]          in_col,
  input  logic signed [mma_pkg::DATA_W-1:0]  in_value,
  output logic                               q_valid,
  output mma_pkg::req_t                      q_req,
  input  logic                               q_pop
);

  localparam int PW = (mma_pkg::QDEPTH > 1) ? $clog2(mma_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(mma_pkg::QDEPTH + 1);

  mma_pkg::req_t  fifo_r [mma_pkg::QDEPTH];
  mma_pkg::req_t  req_cls;
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           in_range;
  logic           push;

  // Out-of-range accesses and unknown ops become no-ops returning zero
  always_comb begin
    in_range      = (32'(in_row) < 32'(DIM)) && (32'(in_col) < 32'(DIM));
    req_cls.row   = in_row;
    req_cls.col   = in_col;
    req_cls.value = in_value;
    case (in_op)
      mma_pkg::OP_WR_A: req_cls.cmd = in_range ? mma_pkg::CMD_WR_A : mma_pkg::CMD_NOP;
      mma_pkg::OP_WR_B: req_cls.cmd = in_range ? mma_pkg::CMD_WR_B : mma_pkg::CMD_NOP;
      mma_pkg::OP_WR_C: req_cls.cmd = in_range ? mma_pkg::CMD_WR_C : mma_pkg::CMD_NOP;
      mma_pkg::OP_MAC:  req_cls.cmd = mma_pkg::CMD_MAC;
      mma_pkg::OP_RD_C: req_cls.cmd = in_range ? mma_pkg::CMD_RD_C : mma_pkg::CMD_NOP;
      default:          req_cls.cmd = mma_pkg::CMD_NOP;
    endcase
  end

  assign in_ready = (count_r != CW'(mma_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_req    = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == mma_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == mma_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= req_cls;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= mma_pkg::QDEPTH)
    else $error("queue count overflow");

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("full queue reports no data");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("push not counted");
`endif

endmodule

/* hw/rtl/mma_back.sv */
// Back end: matrix stores, element access and the sequenced multiply-accumulate.
module mma_back #(
  parameter int DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  mma_pkg::req_t                      q_req,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mma_pkg::DATA_W-1:0]  out_data
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);
  localparam int DW    = mma_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MISS,
    S_MDRN,
    S_MWB,
    S_RESP
  } state_t;

  state_t         state_r, state_nxt;
  logic [IW-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic           v1_r, v1_nxt, v2_r, v2_nxt;
  logic [DW-1:0]  prod_r, prod_nxt, acc_r, acc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  out_data_r, out_data_nxt;

  logic           out_free;
  logic [AW-1:0]  op_addr, a_addr, b_addr, c_addr;
  logic           a_we, b_we, c_we, a_re, b_re, c_re;
  logic [AW-1:0]  c_waddr, c_raddr;
  logic [DW-1:0]  c_wdata;
  logic [DW-1:0]  a_q, b_q, c_q;
  logic           last_k, last_elem;

  assign out_free  = !out_valid_r || out_ready;
  assign op_addr   = AW'(q_req.row) * AW'(DIM) + AW'(q_req.col);
  assign a_addr    = AW'(i_r) * AW'(DIM) + AW'(k_r);
  assign b_addr    = AW'(k_r) * AW'(DIM) + AW'(j_r);
  assign c_addr    = AW'(i_r) * AW'(DIM) + AW'(j_r);
  assign last_k    = (k_r == IW'(DIM - 1));
  assign last_elem = (i_r == IW'(DIM - 1)) && (j_r == IW'(DIM - 1));

  mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(op_addr), .wdata(q_req.value),
    .re(a_re), .raddr(a_addr), .rdata(a_q)
  );

  mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(op_addr), .wdata(q_req.value),
    .re(b_re), .raddr(b_addr), .rdata(b_q)
  );

  mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_q)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    v1_nxt        = 1'b0;
    v2_nxt        = v1_r;
    prod_nxt      = a_q * b_q;
    acc_nxt       = v2_r ? acc_r + prod_r : acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    c_we          = 1'b0;
    a_re          = 1'b0;
    b_re          = 1'b0;
    c_re          = 1'b0;
    c_waddr       = op_addr;
    c_raddr       = op_addr;
    c_wdata       = q_req.value;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_req.cmd)
            mma_pkg::CMD_WR_A: begin
              a_we          = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            mma_pkg::CMD_WR_B: begin
              b_we          = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            mma_pkg::CMD_WR_C: begin
              c_we          = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            mma_pkg::CMD_RD_C: begin
              c_re      = 1'b1;
              state_nxt = S_RD;
            end
            mma_pkg::CMD_MAC: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = S_MISS;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = c_q;
        state_nxt     = S_IDLE;
      end
      S_MISS: begin
        // one A/B pair per cycle; C element read alongside and held
        a_re    = 1'b1;
        b_re    = 1'b1;
        c_re    = 1'b1;
        c_raddr = c_addr;
        v1_nxt  = 1'b1;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = S_MDRN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_MDRN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_MWB;
        end
      end
      S_MWB: begin
        c_we    = 1'b1;
        c_waddr = c_addr;
        c_wdata = c_q + acc_r;
        acc_nxt = '0;
        if (last_elem) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_MISS;
          if (j_r == IW'(DIM - 1)) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_rd_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> !out_valid_r)
    else $error("read data would overwrite a waiting result");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("product stage valid without a read");

  a_wb_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MWB |-> (!v1_r && !v2_r))
    else $error("write-back before the accumulator drained");

  a_last_elem_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWB && last_elem) |=> state_r == S_RESP)
    else $error("multiply did not finish after the last element");
`endif

endmodule

/* hw/rtl/matrix_multiply_accumulate_top.sv */
// Top level of the integer matrix multiply-accumulate block.
// Holds three DIM x DIM matrices A, B and C of 32-bit integers in on-chip RAM.
// Input channel (in_valid/in_ready): one request per handshake, op selects
//   write A, write B, write C (row, col, value), C += A*B, or read C (row, col).
//   Out-of-range indices and unknown ops leave the matrices alone.
// Output channel (out_valid/out_ready): exactly one result per request, in
//   order: the C element for a read, zero for everything else.
// A write or no-op result passes through the queue and the output register; a
//   read also passes through the registered RAM read.
// Throughput: writes one per cycle with a ready receiver; a read holds the
//   back end for its registered RAM read; the multiply is paced by the single
//   multiply-accumulate unit fed from one read port per matrix store.
// A two-entry queue parts the front end from the back end, so requests are
//   still taken while a result waits or a multiply runs, until it fills.
// Reset (rst_n, synchronous, active low) empties the queue and the output
//   register; matrix contents are undefined until written.
// A stalled receiver holds the result in the output register; the back end
//   then takes no new request and in_ready falls once the queue is full.
module matrix_multiply_accumulate_top #(
  parameter int DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mma_pkg::OP_W-1:0]           in_op,
  input  logic [mma_pkg::IDX_W-1:0]          in_row,
  input  logic [mma_pkg::IDX_W-1:0]          in_col,
  input  logic signed [mma_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mma_pkg::DATA_W-1:0]  out_data
);

  // queued, classified request between the two halves
  logic          q_valid;
  logic          q_pop;
  mma_pkg::req_t q_req;

  mma_front #(.DIM(DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  mma_back #(.DIM(DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
